// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising aclk edge outside reset.
`define ASSERT_AT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication checked at every rising aclk edge outside reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/gbn_pkg.sv =====
// Types, codes and constants of the go-back-N sender.
package gbn_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int WIN_W      = 6;
    localparam int PKT_W      = 16;
    localparam int NXT_W      = PKT_W + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [PKT_W-1:0] TOTAL_RST   = 16'd1;
    localparam logic [WIN_W-1:0] THRESH_RST  = 6'd16;
    localparam logic [PKT_W-1:0] TIMEOUT_RST = 16'd1000;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_ACK     = 2'd1,
        OP_FIN_ACK = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_FIN  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_FIN  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FR_ACCEPT,
        FR_BOUND,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        ACT_ISSUE,
        ACT_FIN,
        ACT_DONE
    } action_t;

    typedef enum logic [1:0] {
        CFG_TOTAL   = 2'd0,
        CFG_THRESH  = 2'd1,
        CFG_TIMEOUT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PKT_W-1:0] total;
        logic [WIN_W-1:0] init_thresh;
        logic [PKT_W-1:0] timeout;
    } cfg_t;

    // One run of results: a burst of data packets, a fin or a completion.
    typedef struct packed {
        kind_t            kind;
        logic [PKT_W-1:0] first;
        logic [WIN_W-1:0] count;
        logic [NXT_W-1:0] rlimit;
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] thresh;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

endpackage

// ===== design/gbn_front.sv =====
// Front end: accepts requests, keeps the window state, and queues runs of results.
module gbn_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [15:0]       s_ack_number,
    input  gbn_pkg::cfg_t     cfg,
    output gbn_pkg::job_push_t push,
    input  logic              q_full
);
    import gbn_pkg::*;

    front_state_t     fsm_reg, fsm_next;
    action_t          act_reg, act_next;
    phase_t           phase_reg, phase_next;
    logic [PKT_W-1:0] acked_reg, acked_next;
    logic [NXT_W-1:0] next_reg, next_next;
    logic [WIN_W-1:0] window_reg, window_next;
    logic [WIN_W-1:0] thresh_reg, thresh_next;
    logic [NXT_W-1:0] rlimit_reg, rlimit_next;
    logic [PKT_W-1:0] wend_reg, wend_next;
    logic [PKT_W-1:0] tick_reg, tick_next;
    logic [PKT_W-1:0] bound_reg, bound_next;

    logic             accept;
    logic             acc_go;
    action_t          acc_act;
    logic [PKT_W-1:0] acked_inc;
    logic [WIN_W:0]   win_wide;
    logic [WIN_W-1:0] win_grown;
    logic [WIN_W-1:0] win_half;
    logic [WIN_W-1:0] thr_cut;
    logic             tick_fire;
    logic [PKT_W:0]   bound_sum;
    logic [NXT_W:0]   span;
    logic             span_neg;
    logic             span_big;
    logic [WIN_W-1:0] burst_len;
    logic             push_needed;

    assign accept    = s_valid && s_ready;
    assign acked_inc = acked_reg + PKT_W'(1);
    assign win_wide  = {1'b0, window_reg}
                     + ((window_reg >= thresh_reg) ? (WIN_W+1)'(1) : {1'b0, window_reg});
    assign win_grown = (win_wide > (WIN_W+1)'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                            : win_wide[WIN_W-1:0];
    assign win_half  = window_reg >> 1;
    assign thr_cut   = (win_half > WIN_W'(1)) ? win_half : WIN_W'(1);
    assign tick_fire = tick_reg >= cfg.timeout;
    assign bound_sum = {1'b0, acked_reg} + (PKT_W+1)'(window_reg);

    // Packets still to send in this window: bound - next + 1, capped.
    assign span      = {2'b00, bound_reg} - {1'b0, next_reg};
    assign span_neg  = span[NXT_W];
    assign span_big  = !span_neg && (span[NXT_W-1:0] >= NXT_W'(MAX_WINDOW));
    assign burst_len = span_big ? WIN_W'(MAX_WINDOW) : (span[WIN_W-1:0] + WIN_W'(1));
    assign push_needed = (act_reg != ACT_ISSUE) || !span_neg;

    // Next state
    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FR_ACCEPT: begin
                if (accept && acc_go) begin
                    fsm_next = (acc_act == ACT_ISSUE) ? FR_BOUND : FR_PUSH;
                end
            end
            FR_BOUND: fsm_next = FR_PUSH;
            FR_PUSH: begin
                if (!q_full) begin
                    fsm_next = FR_ACCEPT;
                end
            end
            default: fsm_next = FR_ACCEPT;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready          = (fsm_reg == FR_ACCEPT);
        push.valid       = (fsm_reg == FR_PUSH) && !q_full && push_needed;
        push.job.kind    = KIND_DATA;
        push.job.first   = next_reg[PKT_W-1:0];
        push.job.count   = burst_len;
        push.job.rlimit  = rlimit_reg;
        push.job.window  = window_reg;
        push.job.thresh  = thresh_reg;
        unique case (act_reg)
            ACT_ISSUE: push.job.kind = KIND_DATA;
            ACT_FIN: begin
                push.job.kind   = KIND_FIN;
                push.job.first  = '0;
                push.job.count  = WIN_W'(1);
                push.job.rlimit = '0;
            end
            ACT_DONE: begin
                push.job.kind   = KIND_DONE;
                push.job.first  = '0;
                push.job.count  = WIN_W'(1);
                push.job.rlimit = '0;
            end
            default: push.job.kind = KIND_DATA;
        endcase
    end

    // Window state
    always_comb begin
        act_next    = act_reg;
        phase_next  = phase_reg;
        acked_next  = acked_reg;
        next_next   = next_reg;
        window_next = window_reg;
        thresh_next = thresh_reg;
        rlimit_next = rlimit_reg;
        wend_next   = wend_reg;
        tick_next   = tick_reg;
        bound_next  = bound_reg;
        acc_go      = 1'b0;
        acc_act     = ACT_ISSUE;

        if (accept) begin
            case (op_t'(s_op))
                OP_START: begin
                    acked_next  = '0;
                    next_next   = NXT_W'(1);
                    window_next = WIN_W'(1);
                    thresh_next = cfg.init_thresh;
                    rlimit_next = '0;
                    wend_next   = '0;
                    tick_next   = '0;
                    phase_next  = PH_SEND;
                    acc_go      = 1'b1;
                    acc_act     = ACT_ISSUE;
                end
                OP_ACK: begin
                    if (phase_reg == PH_SEND && acked_inc == s_ack_number) begin
                        acked_next = acked_inc;
                        tick_next  = '0;
                        if (acked_inc >= wend_reg) begin
                            window_next = win_grown;
                            acc_go      = 1'b1;
                            acc_act     = ACT_ISSUE;
                        end
                    end
                end
                OP_FIN_ACK: begin
                    if (phase_reg == PH_FIN) begin
                        phase_next = PH_DONE;
                        acc_go     = 1'b1;
                        acc_act    = ACT_DONE;
                    end
                end
                default: begin
                    // tick
                    if (phase_reg == PH_SEND || phase_reg == PH_FIN) begin
                        if (!tick_fire) begin
                            tick_next = tick_reg + PKT_W'(1);
                        end else if (phase_reg == PH_SEND) begin
                            thresh_next = thr_cut;
                            window_next = WIN_W'(1);
                            rlimit_next = next_reg;
                            next_next   = {1'b0, acked_reg} + NXT_W'(1);
                            acc_go      = 1'b1;
                            acc_act     = ACT_ISSUE;
                        end else begin
                            acc_go  = 1'b1;
                            acc_act = ACT_FIN;
                        end
                    end
                end
            endcase
            if (acc_go) begin
                act_next = acc_act;
            end
        end

        if (fsm_reg == FR_BOUND) begin
            if (acked_reg >= cfg.total) begin
                act_next   = ACT_FIN;
                phase_next = PH_FIN;
            end else if (bound_sum > {1'b0, cfg.total}) begin
                bound_next = cfg.total;
            end else begin
                bound_next = bound_sum[PKT_W-1:0];
            end
        end

        if (fsm_reg == FR_PUSH && !q_full) begin
            tick_next = (act_reg == ACT_DONE) ? tick_reg : '0;
            if (act_reg == ACT_ISSUE) begin
                wend_next = bound_reg;
                if (!span_neg) begin
                    next_next = span_big ? (next_reg + NXT_W'(MAX_WINDOW))
                                         : ({1'b0, bound_reg} + NXT_W'(1));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg    <= FR_ACCEPT;
            act_reg    <= ACT_ISSUE;
            phase_reg  <= PH_IDLE;
            acked_reg  <= '0;
            next_reg   <= NXT_W'(1);
            window_reg <= WIN_W'(1);
            thresh_reg <= THRESH_RST;
            rlimit_reg <= '0;
            wend_reg   <= '0;
            tick_reg   <= '0;
            bound_reg  <= '0;
        end else begin
            fsm_reg    <= fsm_next;
            act_reg    <= act_next;
            phase_reg  <= phase_next;
            acked_reg  <= acked_next;
            next_reg   <= next_next;
            window_reg <= window_next;
            thresh_reg <= thresh_next;
            rlimit_reg <= rlimit_next;
            wend_reg   <= wend_next;
            tick_reg   <= tick_next;
            bound_reg  <= bound_next;
        end
    end

endmodule

// ===== design/gbn_queue.sv =====
// Short queue of result runs between the front and back ends.
module gbn_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  gbn_pkg::job_push_t push,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output gbn_pkg::job_t      head
);
    import gbn_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? (wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/gbn_back.sv =====
// Back end: expands queued runs into result requests through an output register.
module gbn_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  gbn_pkg::job_t q_head,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_kind,
    output logic [15:0]   m_packet_number,
    output logic          m_is_resend,
    output logic [5:0]    m_window_now,
    output logic [5:0]    m_threshold_now,
    output logic          m_last_of_run
);
    import gbn_pkg::*;

    logic             busy_reg, busy_next;
    job_t             cur_reg, cur_next;
    logic             m_valid_reg, m_valid_next;
    kind_t            kind_reg;
    logic [PKT_W-1:0] pkt_reg;
    logic             resend_reg;
    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] thr_reg;
    logic             last_reg;
    logic             load;
    logic             emit;

    assign load  = !m_valid_reg || m_ready;
    assign emit  = load && busy_reg;
    assign q_pop = !busy_reg && !q_empty;

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_packet_number = pkt_reg;
    assign m_is_resend     = resend_reg;
    assign m_window_now    = win_reg;
    assign m_threshold_now = thr_reg;
    assign m_last_of_run   = last_reg;

    always_comb begin
        busy_next    = busy_reg;
        cur_next     = cur_reg;
        m_valid_next = load ? busy_reg : m_valid_reg;
        if (q_pop) begin
            cur_next  = q_head;
            busy_next = 1'b1;
        end else if (emit) begin
            cur_next.first = cur_reg.first + PKT_W'(1);
            cur_next.count = cur_reg.count - WIN_W'(1);
            if (cur_reg.count == WIN_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            kind_reg   <= cur_reg.kind;
            pkt_reg    <= cur_reg.first;
            resend_reg <= (cur_reg.kind == KIND_DATA)
                       && ({1'b0, cur_reg.first} < cur_reg.rlimit);
            win_reg    <= cur_reg.window;
            thr_reg    <= cur_reg.thresh;
            last_reg   <= (cur_reg.count == WIN_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== design/go_back_n_congestion_sender_unit.sv =====
// Top level of the go-back-N sender with slow-start window control.
//
// Input channel (s_*): one request per op - start, data ack, fin ack or timer tick.
// Result channel (m_*): send-data, send-fin and transfer-complete requests, with
//   last_of_run marking the final result caused by one input request.
// Config channel (cfg_*): index 0 total packets, 1 initial threshold, 2 timeout
//   ticks; always ready. The user must write it only while the block is idle;
//   the block itself does not enforce this.
// A request that issues a window passes the front-end states accept, window
//   bound and queue push, then the run queue, the back end's run register and
//   the output register; its results follow one per cycle while m_ready allows,
//   up to 32. A fin ack or fin timeout skips the window bound state; acks that
//   only advance the count and ticks that do not time out give no result.
// Throughput is set by the front end's per-request sequence and by the back
//   end: one result per cycle while m_ready allows, none while it fetches a run.
// A two-entry run queue separates the two ends: the front end keeps taking
//   requests while a burst drains, and stalls only when the queue is full.
// When m_ready is low the output register holds its request; nothing is dropped.
// Reset (aresetn low, synchronous) clears the window state to idle and loads
//   the config registers with 1, 16 and 1000.
module go_back_n_congestion_sender_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_ack_number,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_packet_number,
    output logic        m_is_resend,
    output logic [5:0]  m_window_now,
    output logic [5:0]  m_threshold_now,
    output logic        m_last_of_run,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gbn_pkg::*;

`include "assert_macros.svh"

    cfg_t      cfg_reg, cfg_next;
    job_push_t q_push;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    job_t      q_head;
    logic      ctrl_out;
    logic      ctrl_clean;
    logic      win_ok;

    // Config registers: writes never stall.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TOTAL:   cfg_next.total       = cfg_data;
                CFG_THRESH:  cfg_next.init_thresh = cfg_data[WIN_W-1:0];
                CFG_TIMEOUT: cfg_next.timeout     = cfg_data;
                default:     cfg_next = cfg_reg;   // unmapped index is ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.total       <= TOTAL_RST;
            cfg_reg.init_thresh <= THRESH_RST;
            cfg_reg.timeout     <= TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify requests, update window state, queue runs.
    gbn_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_ack_number (s_ack_number),
        .cfg          (cfg_reg),
        .push         (q_push),
        .q_full       (q_full)
    );

    gbn_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .pop     (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .head    (q_head)
    );

    // Back end: one result per cycle from the head run, unless m_ready holds the output.
    gbn_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_packet_number (m_packet_number),
        .m_is_resend     (m_is_resend),
        .m_window_now    (m_window_now),
        .m_threshold_now (m_threshold_now),
        .m_last_of_run   (m_last_of_run)
    );

    assign ctrl_out   = m_valid && (m_kind != KIND_DATA);
    assign ctrl_clean = (m_packet_number == '0) && !m_is_resend;
    assign win_ok     = (m_window_now != '0) && (m_window_now <= WIN_W'(MAX_WINDOW));

    // Front end only pushes when the queue has room.
    `ASSERT_IMPLY(a_no_overflow, q_push.valid, !q_full, "run pushed into a full queue")
    // Fin and complete are single-result runs.
    `ASSERT_IMPLY(a_ctrl_last, ctrl_out, m_last_of_run, "control result not last")
    // Fin and complete carry no packet number and no resend flag.
    `ASSERT_IMPLY(a_ctrl_clean, ctrl_out, ctrl_clean, "control result carries packet data")
    // Window stays in its legal range on every result.
    `ASSERT_AT_CLK(a_win_range, !m_valid || win_ok, "window out of range")

endmodule
